@@ design/fqk_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fqk_pkg;

   // Fixed field widths of one transaction.
   localparam int KEY_BITS     = 16;
   localparam int PAYLOAD_BITS = 8;
   localparam int OCC_BITS     = 5;

   // Operation codes carried in the request.
   typedef enum logic [1:0] {
      MODE_PUSH   = 2'd0,
      MODE_POP    = 2'd1,
      MODE_SEARCH = 2'd2,
      MODE_NONE   = 2'd3
   } fqk_mode_type;

   // Completion codes carried in the response.
   typedef enum logic [2:0] {
      STATUS_OK    = 3'd0,
      STATUS_DUP   = 3'd1,
      STATUS_FULL  = 3'd2,
      STATUS_EMPTY = 3'd3,
      STATUS_MISS  = 3'd4
   } fqk_status_type;

   typedef struct packed {
      fqk_mode_type            mode;
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
   } fqk_req_type;

   typedef struct packed {
      fqk_status_type          status;
      logic                    found;
      logic [KEY_BITS-1:0]     out_key;
      logic [PAYLOAD_BITS-1:0] out_payload;
      logic [OCC_BITS-1:0]     occupancy;
   } fqk_rsp_type;

   // One queued entry as held in a cell.
   typedef struct packed {
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
   } fqk_entry_type;

   // Per-cycle command shared by all cells of the chain.
   typedef struct packed {
      logic shift;
      logic push;
   } fqk_cell_ctrl_type;

endpackage

`default_nettype wire

@@ design/fqk_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fqk_cell (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire fqk_pkg::fqk_cell_ctrl_type ctrl,
   input  wire logic                      prev_valid,
   input  wire logic                      next_valid,
   input  wire fqk_pkg::fqk_entry_type    next_entry,
   input  wire fqk_pkg::fqk_entry_type    push_entry,
   input  wire logic [fqk_pkg::KEY_BITS-1:0] cmp_key,
   output logic                           valid,
   output fqk_pkg::fqk_entry_type         entry,
   output logic                           match
);
   import fqk_pkg::*;

   logic          valid_ff, valid_in;
   fqk_entry_type entry_ff, entry_in;

   // A pop moves every entry one cell toward the head. A push lands in the
   // first empty cell, which is the one whose older neighbor is occupied.
   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (ctrl.shift) begin
         valid_in = next_valid;
         entry_in = next_entry;
      end else if (ctrl.push && !valid_ff && prev_valid) begin
         valid_in = 1'b1;
         entry_in = push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // Local key compare; keys are unique, so at most one cell matches.
   assign match = valid_ff && (entry_ff.key == cmp_key);
   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

`default_nettype wire

@@ design/fifo_queue_unique_keys_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// First-in first-out queue of up to QUEUE_DEPTH entries with unique keys.
// A transaction is push, pop of the oldest entry, search by key, or no-op.
// Each transaction is accepted when start is high and busy is low (busy is
// never raised), and its response appears on rsp_data with rsp_valid high
// for exactly one cycle, the cycle after acceptance.
// The receiver cannot stall the response, so it must take it in that cycle.
// The entries live in a chain of cells ordered oldest first; every cell
// compares its key with the request key at once, and a pop shifts the whole
// chain by one cell. Occupancy is reported in a five-bit field, so depths
// up to 31 are supported.
module fifo_queue_unique_keys_unit #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire fqk_pkg::fqk_req_type req_data,
   output logic                     rsp_valid,
   output fqk_pkg::fqk_rsp_type     rsp_data
);
   import fqk_pkg::*;

   localparam int CountBits = $clog2(QUEUE_DEPTH + 1);

   logic                    accept;
   logic                    is_push, is_pop;
   fqk_cell_ctrl_type       ctrl;
   fqk_entry_type           push_entry;
   logic [QUEUE_DEPTH-1:0]  cell_valid;
   logic [QUEUE_DEPTH-1:0]  cell_match;
   fqk_entry_type           cell_entry [QUEUE_DEPTH];
   logic                    hit;
   logic                    full;
   fqk_entry_type           hit_entry;

   logic [CountBits-1:0]    count_ff, count_in;
   logic                    rsp_valid_ff;
   fqk_rsp_type             rsp_ff, rsp_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign is_push = (req_data.mode == MODE_PUSH);
   assign is_pop  = (req_data.mode == MODE_POP);

   assign push_entry.key     = req_data.key;
   assign push_entry.payload = req_data.payload;

   assign hit  = |cell_match;
   assign full = cell_valid[QUEUE_DEPTH-1];

   // Commands to the chain; a duplicate key is rejected before the full check.
   assign ctrl.shift = accept && is_pop && cell_valid[0];
   assign ctrl.push  = accept && is_push && !hit && !full;

   // The chain of cells, oldest entry in cell zero.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic          prev_valid;
      logic          next_valid;
      fqk_entry_type next_entry;

      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_mid
         assign prev_valid = cell_valid[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_valid = 1'b0;
         assign next_entry = '0;
      end else begin : g_inner
         assign next_valid = cell_valid[i+1];
         assign next_entry = cell_entry[i+1];
      end

      fqk_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_valid (prev_valid),
         .next_valid (next_valid),
         .next_entry (next_entry),
         .push_entry (push_entry),
         .cmp_key    (req_data.key),
         .valid      (cell_valid[i]),
         .entry      (cell_entry[i]),
         .match      (cell_match[i])
      );
   end

   // Select the matching entry; at most one cell matches.
   always_comb begin
      hit_entry = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         hit_entry = hit_entry | (cell_entry[i] & {$bits(fqk_entry_type){cell_match[i]}});
      end
   end

   // Entry count after this transaction.
   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + CountBits'(1);
      end else if (ctrl.shift) begin
         count_in = count_ff - CountBits'(1);
      end
   end

   // Response of the accepted transaction.
   always_comb begin
      rsp_in             = '0;
      rsp_in.status      = STATUS_OK;
      rsp_in.occupancy   = OCC_BITS'(count_in);
      unique case (req_data.mode)
         MODE_PUSH: begin
            if (hit) begin
               rsp_in.status = STATUS_DUP;
            end else if (full) begin
               rsp_in.status = STATUS_FULL;
            end
         end
         MODE_POP: begin
            if (!cell_valid[0]) begin
               rsp_in.status = STATUS_EMPTY;
            end else begin
               rsp_in.found       = 1'b1;
               rsp_in.out_key     = cell_entry[0].key;
               rsp_in.out_payload = cell_entry[0].payload;
            end
         end
         MODE_SEARCH: begin
            if (!hit) begin
               rsp_in.status = STATUS_MISS;
            end else begin
               rsp_in.found       = 1'b1;
               rsp_in.out_key     = hit_entry.key;
               rsp_in.out_payload = hit_entry.payload;
            end
         end
         MODE_NONE: begin
            rsp_in.status = STATUS_OK;
         end
         default: begin
            rsp_in.status = STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ sim/fqk_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the keyed queue, keeps its own model of the
// queue contents and compares every response with the predicted one.
module fqk_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 busy,
   input  wire fqk_pkg::fqk_req_type req_data,
   input  wire logic                 rsp_valid,
   input  wire fqk_pkg::fqk_rsp_type rsp_data,
   output int                        error_count,
   output int                        pending_count,
   output int                        checked_count
);
   import fqk_pkg::*;

   // Shadow copy of the queue, oldest entry at oldest_slot.
   logic [KEY_BITS-1:0]     queued_keys     [QUEUE_DEPTH];
   logic [PAYLOAD_BITS-1:0] queued_payloads [QUEUE_DEPTH];
   int                      oldest_slot;
   int                      free_slot;
   int                      queued_count;

   // Responses predicted for accepted transactions, oldest first.
   fqk_rsp_type             expected_rsps [$];

   // Returns the slot holding the key, or -1 when it is not queued.
   function automatic int find_key(input logic [KEY_BITS-1:0] key);
      int slot;
      slot = oldest_slot;
      for (int i = 0; i < queued_count; i++) begin
         if (queued_keys[slot] == key)
            return slot;
         slot = (slot + 1) % QUEUE_DEPTH;
      end
      return -1;
   endfunction

   // Applies one transaction to the shadow queue and returns its response.
   function automatic fqk_rsp_type apply_queue_op(input fqk_req_type req);
      fqk_rsp_type rsp;
      int          slot;
      rsp        = '0;
      rsp.status = STATUS_OK;
      case (req.mode)
         MODE_PUSH: begin
            // The duplicate check wins over the full check.
            if (find_key(req.key) >= 0) begin
               rsp.status = STATUS_DUP;
            end else if (queued_count >= QUEUE_DEPTH) begin
               rsp.status = STATUS_FULL;
            end else begin
               queued_keys[free_slot]     = req.key;
               queued_payloads[free_slot] = req.payload;
               free_slot                  = (free_slot + 1) % QUEUE_DEPTH;
               queued_count++;
            end
         end
         MODE_POP: begin
            if (queued_count == 0) begin
               rsp.status = STATUS_EMPTY;
            end else begin
               rsp.found       = 1'b1;
               rsp.out_key     = queued_keys[oldest_slot];
               rsp.out_payload = queued_payloads[oldest_slot];
               oldest_slot     = (oldest_slot + 1) % QUEUE_DEPTH;
               queued_count--;
            end
         end
         MODE_SEARCH: begin
            slot = find_key(req.key);
            if (slot < 0) begin
               rsp.status = STATUS_MISS;
            end else begin
               rsp.found       = 1'b1;
               rsp.out_key     = queued_keys[slot];
               rsp.out_payload = queued_payloads[slot];
            end
         end
         default: begin
            // The unused mode leaves the queue alone.
         end
      endcase
      rsp.occupancy = OCC_BITS'(queued_count);
      return rsp;
   endfunction

   // Reports one response field that differs from its prediction.
   task automatic check_field(input string name, input logic [31:0] expected,
                              input logic [31:0] actual);
      if (expected !== actual) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
         error_count++;
      end
   endtask

   // Responses are checked before the transaction of the same edge is
   // predicted, since a response always belongs to an earlier transaction.
   always @(posedge clock) begin
      fqk_rsp_type expected;
      if (reset) begin
         oldest_slot   = 0;
         free_slot     = 0;
         queued_count  = 0;
         error_count   = 0;
         checked_count = 0;
         expected_rsps.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $error("response with no transaction outstanding: 0x%0h", rsp_data);
               error_count++;
            end else begin
               expected = expected_rsps.pop_front();
               check_field("status", expected.status, rsp_data.status);
               check_field("found", expected.found, rsp_data.found);
               check_field("out_key", expected.out_key, rsp_data.out_key);
               check_field("out_payload", expected.out_payload, rsp_data.out_payload);
               check_field("occupancy", expected.occupancy, rsp_data.occupancy);
               checked_count++;
            end
         end
         if (start && !busy)
            expected_rsps.push_back(apply_queue_op(req_data));
      end
      pending_count = expected_rsps.size();
   end

endmodule

@@ sim/tb_fifo_queue_unique_keys_unit.sv @@
`timescale 1ns / 1ps

// Drives transactions into the keyed queue and gives the final verdict.
module tb_fifo_queue_unique_keys_unit;
   import fqk_pkg::*;

   localparam int QUEUE_DEPTH  = 16;
   localparam int PHASE_ITEMS  = 288;
   localparam int POOL_SIZE    = 24;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   fqk_req_type req_data;
   logic        rsp_valid;
   fqk_rsp_type rsp_data;

   int          error_count;
   int          pending_count;
   int          checked_count;

   // Keys that random transactions reuse so hits and duplicates are common.
   logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
   int                  mode_counts [4];

   fifo_queue_unique_keys_unit #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   fqk_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .error_count  (error_count),
      .pending_count(pending_count),
      .checked_count(checked_count)
   );

   // Free-running clock with a 2 ns period.
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Presents one transaction at a falling edge and holds it until accepted.
   // Returns at the falling edge after acceptance without touching start.
   task automatic send_transaction(input fqk_mode_type mode,
                                   input logic [KEY_BITS-1:0] key,
                                   input logic [PAYLOAD_BITS-1:0] payload);
      fqk_req_type req;
      req.mode    = mode;
      req.key     = key;
      req.payload = payload;
      start    <= 1'b1;
      req_data <= req;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      mode_counts[mode]++;
      @(negedge clock);
   endtask

   // Lowers start for the given number of cycles.
   task automatic idle_cycles(input int count);
      start <= 1'b0;
      repeat (count) @(negedge clock);
   endtask

   // Holds the sender off until every outstanding response has been checked.
   task automatic wait_for_drain();
      start <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      @(negedge clock);
   endtask

   // Random transaction, mostly on pooled keys; the mix favors pushes or pops.
   task automatic send_random(input bit push_heavy);
      int           pick;
      fqk_mode_type mode;
      logic [KEY_BITS-1:0] key;
      pick = $urandom_range(99);
      if (push_heavy)
         mode = (pick < 55) ? MODE_PUSH : (pick < 75) ? MODE_POP :
                (pick < 95) ? MODE_SEARCH : MODE_NONE;
      else
         mode = (pick < 30) ? MODE_PUSH : (pick < 70) ? MODE_POP :
                (pick < 95) ? MODE_SEARCH : MODE_NONE;
      if ($urandom_range(99) < 80)
         key = key_pool[$urandom_range(POOL_SIZE - 1)];
      else
         key = KEY_BITS'($urandom);
      send_transaction(mode, key, PAYLOAD_BITS'($urandom));
   endtask

   // Stimulus: directed corner cases, then random phases with varied idling.
   initial begin
      int idle_pct [4];
      idle_pct = '{0, 48, 48, 11};
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      mode_counts = '{0, 0, 0, 0};
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++)
         key_pool[i] = KEY_BITS'($urandom);
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty queue: pop, search miss and the unused mode.
      send_transaction(MODE_POP, 16'h0000, 8'h00);
      send_transaction(MODE_SEARCH, 16'h1234, 8'h00);
      send_transaction(MODE_NONE, 16'hFFFF, 8'hFF);
      // Extreme keys and payloads, then a duplicate and a search hit.
      send_transaction(MODE_PUSH, 16'h0000, 8'h00);
      send_transaction(MODE_PUSH, 16'hFFFF, 8'hFF);
      send_transaction(MODE_PUSH, 16'h0000, 8'h5A);
      send_transaction(MODE_SEARCH, 16'hFFFF, 8'h00);
      // Fill the queue to its depth.
      for (int i = 1; i <= QUEUE_DEPTH - 2; i++)
         send_transaction(MODE_PUSH, KEY_BITS'(16'h1000 + i * 16'h0111), PAYLOAD_BITS'(i));
      // Full queue: a new key is refused, a duplicate reports as duplicate.
      send_transaction(MODE_PUSH, 16'h7777, 8'hA5);
      send_transaction(MODE_PUSH, 16'hFFFF, 8'h3C);
      send_transaction(MODE_SEARCH, KEY_BITS'(16'h1000 + 14 * 16'h0111), 8'h00);
      send_transaction(MODE_NONE, 16'h0000, 8'h00);
      send_transaction(MODE_POP, 16'h0000, 8'h00);
      wait_for_drain();

      // Random phases alternate between filling and draining the queue.
      for (int phase = 0; phase < 4; phase++) begin
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(99) < idle_pct[phase])
               idle_cycles($urandom_range(1, 3));
            send_random(phase % 2 == 0);
         end
         wait_for_drain();
      end

      // Let the last response settle, then give the verdict.
      start <= 1'b0;
      for (int w = 0; w < 50 && pending_count != 0; w++)
         @(negedge clock);
      repeat (4) @(negedge clock);
      $display("Sent %0d push, %0d pop, %0d search and %0d no-op transactions.",
               mode_counts[MODE_PUSH], mode_counts[MODE_POP],
               mode_counts[MODE_SEARCH], mode_counts[MODE_NONE]);
      $display("Checked %0d responses over full, empty, duplicate and wrapped queues.",
               checked_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("fifo_queue_unique_keys_unit: match");
      end else begin
         $display("fifo_queue_unique_keys_unit: mismatch");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #400000;
      $display("fifo_queue_unique_keys_unit: mismatch");
      $finish;
   end

endmodule
